### hw/rtl/rlfgc_pkg.sv
// Package with payload types, request codes and controller command types for the coloring unit.
package rlfgc_pkg;

    localparam logic [1:0] REQ_LOAD_ROW    = 2'd0;
    localparam logic [1:0] REQ_LOAD_DEGREE = 2'd1;
    localparam logic [1:0] REQ_START       = 2'd2;

    localparam logic CFG_NODE_COUNT    = 1'b0;
    localparam logic CFG_STOP_FRACTION = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  vertex;
        logic [63:0] adj_row;
        logic [6:0]  degree;
    } in_word_t;

    typedef struct packed {
        logic [5:0] vertex_out;
        logic [6:0] color;
        logic [6:0] color_count;
        logic       last;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic run_init;    // clear colors and counters, latch n and the stop limit
        logic scan_clear;  // reset the scan index and best-so-far
        logic scan_step;   // examine one vertex (read data is for the current index)
        logic seed_mode;   // scan ranks uncolored vertices by loaded degree
        logic park;        // move the scan index to the chosen vertex
        logic seed_add;    // open a new class with the best seed
        logic pick_add;    // add the best candidate to the class
        logic fb_mode;     // scan uses the fallback (uncolored degree) score
        logic out_clear;   // reset the output index
        logic out_load;    // load the output register for the current index
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;
        logic scan_done;    // scan index has passed the last vertex
        logic all_colored;
        logic cand_empty;
        logic best_zero;    // no candidate shares a neighbor with the class
        logic pick_none;    // no candidate found at all
        logic over_limit;
    } stat_t;

endpackage

### hw/rtl/rlf_graph_coloring_early_stop_unit.sv
// Top level of the Recursive Largest First graph coloring unit with early stop.
// Load words (adjacency row or degree) are written straight into the stores. A start word colors the graph:
// every seed and every class step is one scan over the n vertices at one vertex per cycle,
// with a popcount of a 64-bit masked row, plus bookkeeping states (park, add, check); the fallback
// ranking adds a second scan. The n result words then stream out, each held until the
// receiver takes it, and no new input word is accepted until the last one is taken.
// The single scan unit and the one read port of the adjacency store set the run time.
module rlf_graph_coloring_early_stop_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [16:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rlfgc_pkg::in_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rlfgc_pkg::out_word_t out_word
);

    rlfgc_pkg::cmd_t  cmd;
    rlfgc_pkg::stat_t stat;
    logic             load_row;
    logic             load_degree;

    rlfgc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (in_word.req_type),
        .load_row    (load_row),
        .load_degree (load_degree),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    rlfgc_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .load_row    (load_row),
        .load_degree (load_degree),
        .in_word     (in_word),
        .cmd         (cmd),
        .stat        (stat),
        .out_word    (out_word)
    );

endmodule

### hw/rtl/rlfgc_datapath.sv
// Datapath of the coloring unit: stores, class sets, one-vertex-per-cycle scan and output register.
module rlfgc_datapath #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [16:0]         cfg_data,
    input  logic                load_row,
    input  logic                load_degree,
    input  rlfgc_pkg::in_word_t in_word,
    input  rlfgc_pkg::cmd_t     cmd,
    output rlfgc_pkg::stat_t    stat,
    output rlfgc_pkg::out_word_t out_word
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // Stores, undefined until written.
    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [6:0]              deg_mem [MAX_VERTICES];
    // Colors of the current run. An entry counts only once its vertex has left the
    // uncolored set, so the store needs no clearing between runs.
    logic [6:0]              color_mem [MAX_VERTICES];

    logic [6:0]  node_count_reg;
    logic [16:0] stop_fraction_reg;

    logic [MAX_VERTICES-1:0] unc_reg, unc_next;
    logic [MAX_VERTICES-1:0] valid_reg;
    logic [MAX_VERTICES-1:0] cls_nb_reg, cls_nb_next;
    logic [MAX_VERTICES-1:0] cand_reg;
    logic [CW-1:0]           n_reg;
    logic [CW-1:0]           total_reg;
    logic [CW:0]             limit_reg;
    logic [6:0]              col_reg;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [IW-1:0]           best_idx_reg;
    logic [6:0]              best_val_reg;
    logic                    best_found_reg;
    logic [MAX_VERTICES-1:0] row_rd_reg;
    logic [6:0]              deg_rd_reg;

    logic [IW-1:0]           idx;
    logic [IW-1:0]           rd_idx;
    logic                    idx_in;
    logic [CW-1:0]           n_sat;
    logic [23:0]             limit_prod;
    logic [MAX_VERTICES-1:0] score_vec;
    logic [6:0]              score;
    logic                    take;
    logic [IW-1:0]           add_idx;
    logic                    do_add;

    assign idx    = idx_reg[IW-1:0];
    assign idx_in = (idx_reg < n_reg);

    // Index the scan holds in the next cycle; the stores are read there, so the registered read data belongs to it.
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.scan_clear || cmd.out_clear)
            idx_next = '0;
        else if (cmd.scan_step || cmd.out_load)
            idx_next = idx_reg + CW'(1);
        else if (cmd.park)
            idx_next = CW'(best_idx_reg);
    end

    assign rd_idx = idx_next[IW-1:0];

    // Loads write straight into the stores. Read data always belongs to idx_reg.
    always_ff @(posedge clk)
    begin
        if (load_row && (32'(in_word.vertex) < MAX_VERTICES))
        begin
            adj_mem[in_word.vertex[IW-1:0]] <= in_word.adj_row[MAX_VERTICES-1:0];
        end
        if (load_degree && (32'(in_word.vertex) < MAX_VERTICES))
        begin
            deg_mem[in_word.vertex[IW-1:0]] <= in_word.degree;
        end
        if (do_add)
        begin
            color_mem[add_idx] <= cmd.seed_add ? col_reg + 7'd1 : col_reg;
        end
        row_rd_reg <= adj_mem[rd_idx];
        deg_rd_reg <= deg_mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg    <= 7'd64;
            stop_fraction_reg <= 17'h10000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlfgc_pkg::CFG_NODE_COUNT:    node_count_reg <= cfg_data[6:0];
                rlfgc_pkg::CFG_STOP_FRACTION: stop_fraction_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    assign n_sat = (32'(node_count_reg) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                        : CW'(node_count_reg);
    assign limit_prod = 24'(n_sat) * 24'(stop_fraction_reg);

    // Score of the vertex under the scan index.
    always_comb
    begin
        if (cmd.fb_mode)
            score_vec = row_rd_reg & unc_reg & valid_reg;
        else
            score_vec = row_rd_reg & cls_nb_reg & unc_reg & valid_reg;
        score = '0;
        for (int k = 0; k < MAX_VERTICES; k++)
            score = score + 7'(score_vec[k]);
    end

    // Seed scan: uncolored, degree >= best, last wins. Class scan: candidate, strict greater
    // (or first in fallback), first wins.
    always_comb
    begin
        take = 1'b0;
        if (idx_in)
        begin
            if (cmd.seed_mode)
                take = unc_reg[idx] && (!best_found_reg || deg_rd_reg >= best_val_reg);
            else if (cmd.fb_mode)
                take = cand_reg[idx] && (!best_found_reg || score > best_val_reg);
            else
                take = cand_reg[idx] && (score > best_val_reg);
        end
    end

    assign do_add  = cmd.seed_add || cmd.pick_add;
    assign add_idx = best_idx_reg;

    always_comb
    begin
        unc_next    = unc_reg;
        cls_nb_next = cls_nb_reg;
        if (do_add)
        begin
            unc_next[add_idx] = 1'b0;
            cls_nb_next = (cmd.seed_add ? '0 : cls_nb_reg) | (row_rd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unc_reg        <= '0;
            valid_reg      <= '0;
            cls_nb_reg     <= '0;
            cand_reg       <= '0;
            n_reg          <= '0;
            total_reg      <= '0;
            limit_reg      <= '0;
            col_reg        <= '0;
            idx_reg        <= '0;
            best_idx_reg   <= '0;
            best_val_reg   <= '0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;

            if (cmd.run_init)
            begin
                n_reg     <= n_sat;
                limit_reg <= (CW+1)'(limit_prod[23:16]);
                total_reg <= '0;
                col_reg   <= '0;
                cls_nb_reg <= '0;
                cand_reg  <= '0;
                for (int k = 0; k < MAX_VERTICES; k++)
                begin
                    unc_reg[k]   <= (k < 32'(n_sat));
                    valid_reg[k] <= (k < 32'(n_sat));
                end
            end
            else if (do_add)
            begin
                // Row of the added vertex is read with the scan index parked on it.
                if (cmd.seed_add)
                    col_reg <= col_reg + 7'd1;
                total_reg  <= total_reg + CW'(1);
                unc_reg    <= unc_next;
                cls_nb_reg <= cls_nb_next;
                cand_reg   <= unc_next & ~cls_nb_next;
            end

            if (cmd.scan_clear || cmd.out_clear)
            begin
                best_found_reg <= 1'b0;
                best_val_reg   <= '0;
                best_idx_reg   <= '0;
            end
            else if (cmd.scan_step && take)
            begin
                best_found_reg <= 1'b1;
                best_val_reg   <= cmd.seed_mode ? deg_rd_reg : score;
                best_idx_reg   <= idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_word.vertex_out  <= 6'(idx);
            out_word.color       <= unc_reg[idx] ? 7'd0 : color_mem[idx];
            out_word.color_count <= col_reg;
            out_word.last        <= (idx_reg + CW'(1) == n_reg);
        end
    end

    always_comb
    begin
        stat.n_zero      = (n_reg == '0);
        stat.scan_done   = !idx_in;
        stat.all_colored = (total_reg >= n_reg);
        stat.cand_empty  = (cand_reg == '0);
        stat.best_zero   = (best_val_reg == '0);
        stat.pick_none   = !best_found_reg;
        stat.over_limit  = ({1'b0, total_reg} > limit_reg);
    end

endmodule

### hw/rtl/rlfgc_ctrl.sv
// Controller state machine of the coloring unit.
module rlfgc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       req_type,
    output logic             load_row,
    output logic             load_degree,
    output logic             out_valid,
    input  logic             out_ready,
    output rlfgc_pkg::cmd_t  cmd,
    input  rlfgc_pkg::stat_t stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_SEED  = 4'd2;
    localparam logic [3:0] S_SADD  = 4'd3;
    localparam logic [3:0] S_PICK  = 4'd4;
    localparam logic [3:0] S_FBGO  = 4'd5;
    localparam logic [3:0] S_FB    = 4'd6;
    localparam logic [3:0] S_PADD  = 4'd7;
    localparam logic [3:0] S_CHECK = 4'd8;
    localparam logic [3:0] S_OLOAD = 4'd9;
    localparam logic [3:0] S_OSEND = 4'd10;
    localparam logic [3:0] S_PARK  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       add_seed_reg, add_seed_next;
    logic       accept;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign load_row    = accept && (req_type == rlfgc_pkg::REQ_LOAD_ROW);
    assign load_degree = accept && (req_type == rlfgc_pkg::REQ_LOAD_DEGREE);
    assign out_valid   = (state_reg == S_OSEND);

    always_comb
    begin
        state_next    = state_reg;
        add_seed_next = add_seed_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req_type == rlfgc_pkg::REQ_START)
                begin
                    cmd.run_init = 1'b1;
                    state_next   = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.scan_clear = 1'b1;
                if (stat.n_zero)
                    state_next = S_IDLE;
                else
                    state_next = S_SEED;
            end
            S_SEED:
            begin
                cmd.seed_mode = 1'b1;
                if (stat.scan_done)
                begin
                    add_seed_next = 1'b1;
                    state_next    = S_PARK;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_PICK:
            begin
                if (stat.scan_done)
                begin
                    if (stat.best_zero)
                        state_next = S_FBGO;
                    else
                    begin
                        add_seed_next = 1'b0;
                        state_next    = S_PARK;
                    end
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_FBGO:
            begin
                cmd.scan_clear = 1'b1;
                state_next     = S_FB;
            end
            S_FB:
            begin
                cmd.fb_mode = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.pick_none)
                        state_next = S_CHECK;
                    else
                    begin
                        add_seed_next = 1'b0;
                        state_next    = S_PARK;
                    end
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_PARK:
            begin
                // Scan index is moved to the chosen vertex so its row can be read.
                cmd.park   = 1'b1;
                state_next = add_seed_reg ? S_SADD : S_PADD;
            end
            S_SADD:
            begin
                cmd.seed_add = 1'b1;
                state_next   = S_CHECK;
            end
            S_PADD:
            begin
                cmd.pick_add = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.scan_clear = 1'b1;
                if (!stat.cand_empty)
                    state_next = S_PICK;
                else if (stat.all_colored || stat.over_limit)
                    state_next = S_OLOAD;
                else
                    state_next = S_SEED;
            end
            S_OLOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OSEND;
            end
            S_OSEND:
            begin
                if (out_ready)
                begin
                    if (stat.scan_done)
                        state_next = S_IDLE;
                    else
                        state_next = S_OLOAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            add_seed_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            add_seed_reg <= add_seed_next;
        end
    end

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the graph coloring unit with early stop.
module tb_top;

    // A start colors the graph and then sends its result words, and the receiver may stall on
    // top of that. This bound is many times the slowest correct run of the whole test.
    localparam int CYCLE_LIMIT = 3000000;
    // Cycles to let pass after the last expected word before a register write. A start
    // with no vertices in use gives no result word but may still be busy in its init state.
    localparam int SETTLE_CYCLES = 64;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_index;
    logic [16:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    rlfgc_pkg::in_word_t  in_word;
    logic      out_valid;
    logic      out_ready;
    rlfgc_pkg::out_word_t out_word;

    // Our own copy of the block's stores and registers, updated at each accepted word and register write.
    logic [63:0] adj_rows [64];
    logic [6:0]  loaded_degree [64];
    logic [6:0]  vertex_color [64];
    logic [6:0]  node_count_reg;
    logic [16:0] stop_fraction_reg;

    // Color reports still due from the block, oldest first.
    rlfgc_pkg::out_word_t pending_colors [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    // While set, neither side idles, so that a long stretch runs at full rate.
    bit steady_flow;

    rlf_graph_coloring_early_stop_unit #(.MAX_VERTICES(64)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
        mismatch_count++;
    endtask

    // Recursive Largest First with the early stop. Every class is seeded with the uncolored
    // vertex of highest loaded degree (the last index wins ties). The class then grows by
    // the candidate sharing the most uncolored neighbors with the class; if no candidate
    // shares any, the candidate with the highest uncolored degree is taken. Candidate ties
    // go to the lowest index. The expected color reports are queued at the end.
    task automatic predict_coloring();
        int        n;
        int        stop_limit;
        int        colored;
        int        class_id;
        int        best;
        int        seed;
        int        pick;
        int        score;
        logic [63:0] in_use;
        logic [63:0] uncolored;
        logic [63:0] class_rows;
        logic [63:0] candidates;
        rlfgc_pkg::out_word_t w;
        n = (node_count_reg > 64) ? 64 : int'(node_count_reg);
        foreach (vertex_color[v])
            vertex_color[v] = '0;
        if (n == 0)
            return;
        in_use = (n == 64) ? '1 : ((64'd1 << n) - 64'd1);
        stop_limit = int'((longint'(n) * longint'(stop_fraction_reg)) >>> 16);
        colored = 0;
        class_id = 0;
        while (colored < n)
        begin
            best = -1;
            seed = 0;
            for (int v = 0; v < n; v++)
                if (vertex_color[v] == 0 && int'(loaded_degree[v]) >= best)
                begin
                    best = int'(loaded_degree[v]);
                    seed = v;
                end
            class_id++;
            class_rows = '0;
            pick = seed;
            do
            begin
                vertex_color[pick] = 7'(class_id);
                colored++;
                class_rows |= adj_rows[pick];
                uncolored = '0;
                for (int v = 0; v < n; v++)
                    if (vertex_color[v] == 0)
                        uncolored[v] = 1'b1;
                candidates = uncolored & ~class_rows;
                if (candidates == '0)
                    break;
                pick = -1;
                best = 0;
                for (int v = 0; v < n; v++)
                    if (candidates[v])
                    begin
                        score = $countones(class_rows & adj_rows[v] & uncolored & in_use);
                        if (score > best)
                        begin
                            best = score;
                            pick = v;
                        end
                    end
                // Nobody shares a neighbor with the class: rank by uncolored degree.
                if (best == 0)
                    for (int v = 0; v < n; v++)
                        if (candidates[v])
                        begin
                            score = $countones(adj_rows[v] & uncolored & in_use);
                            if (pick < 0 || score > best)
                            begin
                                best = score;
                                pick = v;
                            end
                        end
            end
            while (1);
            if (colored > stop_limit)
                break;
        end
        for (int v = 0; v < n; v++)
        begin
            w.vertex_out  = 6'(v);
            w.color       = vertex_color[v];
            w.color_count = 7'(class_id);
            w.last        = (v == n - 1);
            pending_colors.push_back(w);
        end
    endtask

    // Offers one word and returns at the edge where it is accepted, then updates our copy
    // of the stores. The valid stays high when the next word follows with no gap.
    task automatic send_word(input rlfgc_pkg::in_word_t w);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(99) < 6)
            gap = 1;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        case (w.req_type)
            rlfgc_pkg::REQ_LOAD_ROW:    adj_rows[w.vertex] = w.adj_row;
            rlfgc_pkg::REQ_LOAD_DEGREE: loaded_degree[w.vertex] = w.degree;
            rlfgc_pkg::REQ_START:       predict_coloring();
            default:                    ;
        endcase
    endtask

    // Lowers the valid and waits until every expected word has arrived, then a little longer.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_register(input logic idx, input int value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 17'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == rlfgc_pkg::CFG_NODE_COUNT)
            node_count_reg = 7'(value);
        else
            stop_fraction_reg = 17'(value);
    endtask

    task automatic send_load(input logic [1:0] kind, input int v, input logic [63:0] row,
                             input int deg);
        rlfgc_pkg::in_word_t w;
        w.req_type = kind;
        w.vertex   = 6'(v);
        w.adj_row  = row;
        w.degree   = 7'(deg);
        send_word(w);
    endtask

    // A start word carries random content in the fields the block ignores.
    task automatic send_start();
        send_load(rlfgc_pkg::REQ_START, $urandom_range(63), {$urandom, $urandom},
                  $urandom_range(127));
    endtask

    // Loads a random undirected graph on vertices 0..n-1. With junk set, row bits at or
    // above n carry random garbage that the block must ignore. Degrees are mostly the true
    // degree and sometimes random, including the extremes 0 and 64.
    task automatic load_graph(input int n, input int density, input bit junk);
        logic [63:0] rows [64];
        logic [63:0] in_use;
        int          deg;
        in_use = (n == 64) ? '1 : ((64'd1 << n) - 64'd1);
        foreach (rows[i])
            rows[i] = '0;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if ($urandom_range(99) < density)
                begin
                    rows[i][j] = 1'b1;
                    rows[j][i] = 1'b1;
                end
        for (int i = 0; i < n; i++)
        begin
            if (junk)
                rows[i] |= {$urandom, $urandom} & ~in_use;
            deg = $countones(rows[i] & in_use);
            if ($urandom_range(3) == 0)
                deg = $urandom_range(1) ? 64 : $urandom_range(64);
            send_load(rlfgc_pkg::REQ_LOAD_ROW, i, rows[i], 0);
            send_load(rlfgc_pkg::REQ_LOAD_DEGREE, i, '0, deg);
        end
    endtask

    // One vertex whose row is all ones: the self loop and the bits above n are ignored.
    task automatic test_single_vertex();
        write_register(rlfgc_pkg::CFG_NODE_COUNT, 1);
        write_register(rlfgc_pkg::CFG_STOP_FRACTION, 65536);
        send_load(rlfgc_pkg::REQ_LOAD_ROW, 0, '1, 0);
        send_load(rlfgc_pkg::REQ_LOAD_DEGREE, 0, '0, 64);
        send_start();
    endtask

    // With no vertices in use a start gives no word at all.
    task automatic test_zero_vertices();
        write_register(rlfgc_pkg::CFG_NODE_COUNT, 0);
        send_start();
    endtask

    // The unknown request code is ignored, whatever its payload; the stored rows stay.
    task automatic test_unknown_request();
        write_register(rlfgc_pkg::CFG_NODE_COUNT, 3);
        send_load(2'd3, 0, '1, 127);
        send_load(2'd3, 63, '0, 0);
        send_start();
    endtask

    // A zero fraction stops after the first class; the largest fraction never stops early,
    // and a fraction just below one stops only when everything is colored.
    task automatic test_stop_fraction();
        write_register(rlfgc_pkg::CFG_STOP_FRACTION, 0);
        send_start();
        write_register(rlfgc_pkg::CFG_STOP_FRACTION, 131071);
        send_start();
        write_register(rlfgc_pkg::CFG_STOP_FRACTION, 65535);
        send_start();
    endtask

    // All 64 vertices in use, once with a node count that saturates to the maximum.
    // Neither side idles here, so this is the long stretch at full rate.
    task automatic test_full_graph();
        steady_flow = 1'b1;
        write_register(rlfgc_pkg::CFG_NODE_COUNT, 64);
        write_register(rlfgc_pkg::CFG_STOP_FRACTION, 65536);
        load_graph(64, 30, 1'b0);
        send_start();
        write_register(rlfgc_pkg::CFG_NODE_COUNT, 127);
        write_register(rlfgc_pkg::CFG_STOP_FRACTION, 32768);
        send_start();
        wait_idle();
        steady_flow = 1'b0;
    endtask

    // Random settings on the graph already stored. Each round rewrites one row with random
    // content, bits above n included, or one degree, and both sides idle at random.
    task automatic test_random_graphs();
        int n;
        int v;
        for (int round = 0; round < 4; round++)
        begin
            n = ($urandom_range(3) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
            write_register(rlfgc_pkg::CFG_NODE_COUNT, n);
            case ($urandom_range(3))
                0:       write_register(rlfgc_pkg::CFG_STOP_FRACTION, $urandom_range(65536));
                1:       write_register(rlfgc_pkg::CFG_STOP_FRACTION,
                                        $urandom_range(65537, 131071));
                default: write_register(rlfgc_pkg::CFG_STOP_FRACTION,
                                        $urandom_range(16384, 49152));
            endcase
            v = $urandom_range(n - 1);
            if ($urandom_range(1) == 0)
                send_load(rlfgc_pkg::REQ_LOAD_ROW, v, {$urandom, $urandom}, 0);
            else
                send_load(rlfgc_pkg::REQ_LOAD_DEGREE, v, '0, $urandom_range(64));
            if ($urandom_range(3) == 0)
                send_load(2'd3, $urandom_range(63), {$urandom, $urandom}, $urandom_range(127));
            send_start();
            // A second start on the same graph checks that colors are cleared between runs.
            if ($urandom_range(2) == 0)
                send_start();
        end
    endtask

    // The receiver stalls at random, except in the steady stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady_flow || ($urandom_range(99) >= 6);
    end

    // Each accepted word is checked against the oldest expected report.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_colors.size() == 0)
                report_mismatch("word with nothing expected, vertex", out_word.vertex_out, -1);
            else
            begin
                rlfgc_pkg::out_word_t want;
                want = pending_colors.pop_front();
                if (out_word.vertex_out != want.vertex_out)
                    report_mismatch("vertex_out", out_word.vertex_out, want.vertex_out);
                if (out_word.color != want.color)
                    report_mismatch("color", out_word.color, want.color);
                if (out_word.color_count != want.color_count)
                    report_mismatch("color_count", out_word.color_count, want.color_count);
                if (out_word.last != want.last)
                    report_mismatch("last", out_word.last, want.last);
            end
        end
    end

    // Watchdog: a run that hangs ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        steady_flow       = 1'b0;
        node_count_reg    = 7'd64;
        stop_fraction_reg = 17'd65536;
        foreach (adj_rows[i])
        begin
            adj_rows[i]      = '0;
            loaded_degree[i] = '0;
            vertex_color[i]  = '0;
        end
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_word   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_full_graph();
        test_single_vertex();
        test_zero_vertices();
        test_unknown_request();
        test_stop_fraction();
        test_random_graphs();

        wait_idle();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
